### hw/rtl/clws_pkg.sv
// Shared widths, codes and the control program of the character LCD write sequencer.
// Depends on nothing; every other file of the block imports it.
package clws_pkg;

  localparam int CmdW      = 3;
  localparam int ByteW     = 8;
  localparam int NumW      = 16;
  localparam int PatW      = 64;
  localparam int WaitW     = 6;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 8;
  localparam int PcW       = 5;
  localparam int CntW      = 3;
  localparam int DigitW    = 4;
  localparam int PowW      = 17;
  localparam int NumDigits = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_INIT      = 3'd0,
    CMD_CMD_BYTE  = 3'd1,
    CMD_DATA_BYTE = 3'd2,
    CMD_CURSOR    = 3'd3,
    CMD_NUMBER    = 3'd4,
    CMD_GLYPH     = 3'd5
  } req_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BUS_MODE   = 3'd0,
    REG_LINE1_BASE = 3'd1,
    REG_LINE2_BASE = 3'd2,
    REG_DDRAM_BASE = 3'd3,
    REG_CGRAM_BASE = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SRC_CONST     = 3'd0,
    SRC_BYTE      = 3'd1,
    SRC_GLYPH_CMD = 3'd2,
    SRC_PATTERN   = 3'd3,
    SRC_CURSOR    = 3'd4,
    SRC_DIGIT     = 3'd5
  } byte_src_e;

  typedef struct packed {
    byte_src_e          src;
    logic               rs;
    logic [WaitW-1:0]   wait_ms;
    logic [ByteW-1:0]   value;
    logic               last;
    logic               loop;
    logic [CntW-1:0]    loop_end;
  } ucode_t;

  localparam logic [PcW-1:0] PcInit4    = 5'd0;
  localparam logic [PcW-1:0] PcInit8    = 5'd6;
  localparam logic [PcW-1:0] PcCmdByte  = 5'd10;
  localparam logic [PcW-1:0] PcDataByte = 5'd11;
  localparam logic [PcW-1:0] PcCursor   = 5'd12;
  localparam logic [PcW-1:0] PcNumber   = 5'd13;
  localparam logic [PcW-1:0] PcGlyph    = 5'd14;

  localparam logic [CntW-1:0] PatLastCnt   = 3'd7;
  localparam logic [CntW-1:0] DigitLastCnt = CntW'(NumDigits - 1);

  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      // init, 4-bit bus
      5'd0:  w = '{SRC_CONST,     1'b0, 6'd50, 8'h33, 1'b0, 1'b0, 3'd0};
      5'd1:  w = '{SRC_CONST,     1'b0, 6'd0,  8'h32, 1'b0, 1'b0, 3'd0};
      5'd2:  w = '{SRC_CONST,     1'b0, 6'd0,  8'h28, 1'b0, 1'b0, 3'd0};
      5'd3:  w = '{SRC_CONST,     1'b0, 6'd0,  8'h0C, 1'b0, 1'b0, 3'd0};
      5'd4:  w = '{SRC_CONST,     1'b0, 6'd0,  8'h01, 1'b0, 1'b0, 3'd0};
      5'd5:  w = '{SRC_CONST,     1'b0, 6'd2,  8'h06, 1'b1, 1'b0, 3'd0};
      // init, 8-bit bus
      5'd6:  w = '{SRC_CONST,     1'b0, 6'd50, 8'h38, 1'b0, 1'b0, 3'd0};
      5'd7:  w = '{SRC_CONST,     1'b0, 6'd1,  8'h0C, 1'b0, 1'b0, 3'd0};
      5'd8:  w = '{SRC_CONST,     1'b0, 6'd1,  8'h01, 1'b0, 1'b0, 3'd0};
      5'd9:  w = '{SRC_CONST,     1'b0, 6'd20, 8'h06, 1'b1, 1'b0, 3'd0};
      5'd10: w = '{SRC_BYTE,      1'b0, 6'd0,  8'h00, 1'b1, 1'b0, 3'd0};
      5'd11: w = '{SRC_BYTE,      1'b1, 6'd0,  8'h00, 1'b1, 1'b0, 3'd0};
      5'd12: w = '{SRC_CURSOR,    1'b0, 6'd0,  8'h00, 1'b1, 1'b0, 3'd0};
      5'd13: w = '{SRC_DIGIT,     1'b1, 6'd0,  8'h00, 1'b1, 1'b1, DigitLastCnt};
      // glyph load and show
      5'd14: w = '{SRC_GLYPH_CMD, 1'b0, 6'd0,  8'h00, 1'b0, 1'b0, 3'd0};
      5'd15: w = '{SRC_PATTERN,   1'b1, 6'd0,  8'h00, 1'b0, 1'b1, PatLastCnt};
      5'd16: w = '{SRC_CURSOR,    1'b0, 6'd0,  8'h00, 1'b0, 1'b0, 3'd0};
      5'd17: w = '{SRC_BYTE,      1'b1, 6'd0,  8'h00, 1'b1, 1'b0, 3'd0};
      default: w = '{SRC_CONST,   1'b0, 6'd0,  8'h00, 1'b1, 1'b0, 3'd0};
    endcase
    return w;
  endfunction

  function automatic logic [PowW-1:0] pow10(logic [CntW-1:0] idx);
    logic [PowW-1:0] p;
    case (idx)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      default: p = 17'd0;
    endcase
    return p;
  endfunction

endpackage

### hw/rtl/clws_if.sv
// Valid/ready channels of the character LCD write sequencer: requests and strobe words.
// Depends on clws_pkg for the field widths.
interface clws_req_if;
  import clws_pkg::*;
  logic                valid;
  logic                ready;
  logic [CmdW-1:0]     cmd;
  logic [ByteW-1:0]    byte_value;
  logic [NumW-1:0]     number;
  logic [ByteW-1:0]    col;
  logic [ByteW-1:0]    row;
  logic [PatW-1:0]     pattern;
  modport source (output valid, cmd, byte_value, number, col, row, pattern, input ready);
  modport sink   (input valid, cmd, byte_value, number, col, row, pattern, output ready);
endinterface

interface clws_strobe_if;
  import clws_pkg::*;
  logic                valid;
  logic                ready;
  logic                reg_select;
  logic [ByteW-1:0]    data_lines;
  logic [WaitW-1:0]    wait_before_ms;
  logic                last;
  modport source (output valid, reg_select, data_lines, wait_before_ms, last, input ready);
  modport sink   (input valid, reg_select, data_lines, wait_before_ms, last, output ready);
endinterface

### hw/rtl/clws_digit.sv
// Decimal digit extractor: one digit of a 16-bit value per call, most significant first.
// Depends on clws_pkg for widths and the power-of-ten table.
module clws_digit (
  input  logic [clws_pkg::NumW-1:0]   rem_i,
  input  logic [clws_pkg::CntW-1:0]   pos_i,
  output logic [clws_pkg::DigitW-1:0] digit_o,
  output logic [clws_pkg::NumW-1:0]   rem_o
);
  import clws_pkg::*;

  logic [PowW-1:0] pow;
  logic [PowW-1:0] mult;
  logic [PowW-1:0] sub;
  logic [PowW-1:0] rem_ext;

  always_comb begin
    pow     = pow10(DigitLastCnt - pos_i);
    rem_ext = {1'b0, rem_i};
    digit_o = '0;
    sub     = '0;
    for (int c = 1; c <= 9; c++) begin
      mult = PowW'(c) * pow;
      if (rem_ext >= mult) begin
        digit_o = DigitW'(c);
        sub     = mult;
      end
    end
    rem_o = NumW'(rem_ext - sub);
  end

endmodule

### hw/rtl/char_lcd_write_sequencer.sv
// Character LCD write sequencer: expands one request into display enable strobes.
// A request is taken only while the sequencer is idle. It then emits one strobe word per
// cycle while the sink keeps up: one word for a byte on the 8-bit bus, and two (high
// nibble, then low nibble) on the 4-bit bus, up to 22 words for a glyph request. A number
// emits no strobe for a leading zero that it drops, but still steps past it. The step
// counter walks the control program in clws_pkg, one control word per byte or per looping
// run of bytes. A request keeps the sequencer busy through its strobes, its skipped zeros
// and any stalls on the strobe side. An unused request code is taken and emits nothing.
// The last word of a run sits in the output register while the next request is accepted.
// Depends on clws_pkg, clws_if and clws_digit.
module char_lcd_write_sequencer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  clws_req_if.sink                        req_i,
  clws_strobe_if.source                   strobe_o,
  input  logic                            cfg_we_i,
  input  logic [clws_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [clws_pkg::CfgDataW-1:0]   cfg_data_i
);
  import clws_pkg::*;

  logic             bus_mode_q;
  logic [ByteW-1:0] line1_base_q;
  logic [ByteW-1:0] line2_base_q;
  logic [ByteW-1:0] ddram_base_q;
  logic [ByteW-1:0] cgram_base_q;

  logic             busy_q;
  logic [PcW-1:0]   pc_q;
  logic [CntW-1:0]  cnt_q;
  logic             nib_q;
  logic             seen_q;

  logic [ByteW-1:0] bv_q;
  logic [ByteW-1:0] col_q;
  logic [ByteW-1:0] row_q;
  logic [PatW-1:0]  pat_q;
  logic [NumW-1:0]  rem_q;
  logic [NumW-1:0]  rem_d;

  logic             out_valid_q;
  logic             out_rs_q;
  logic [ByteW-1:0] out_data_q;
  logic [WaitW-1:0] out_wait_q;
  logic             out_last_q;

  ucode_t           uc;
  logic [DigitW-1:0] digit;
  logic [ByteW-1:0] cursor_pos;
  logic [ByteW-1:0] byte_val;
  logic             loop_done;
  logic             skip;
  logic             out_free;
  logic             emit;
  logic             byte_done;
  logic             run_end;
  logic             req_fire;
  logic             entry_ok;
  logic [PcW-1:0]   entry_pc;
  logic [ByteW-1:0] strobe_data;

  clws_digit u_digit (
    .rem_i   (rem_q),
    .pos_i   (cnt_q),
    .digit_o (digit),
    .rem_o   (rem_d)
  );

  always_comb begin
    uc = ucode_rom(pc_q);
    if (row_q == 8'd0) begin
      cursor_pos = col_q + line1_base_q;
    end else if (row_q == 8'd1) begin
      cursor_pos = col_q + line2_base_q;
    end else begin
      cursor_pos = '0;
    end
    case (uc.src)
      SRC_CONST:     byte_val = uc.value;
      SRC_BYTE:      byte_val = bv_q;
      SRC_GLYPH_CMD: byte_val = {bv_q[4:0], 3'b000} + cgram_base_q;
      SRC_PATTERN:   byte_val = pat_q[{cnt_q, 3'b000} +: ByteW];
      SRC_CURSOR:    byte_val = cursor_pos + ddram_base_q;
      SRC_DIGIT:     byte_val = 8'h30 | {4'b0000, digit};
      default:       byte_val = uc.value;
    endcase
    loop_done = !uc.loop || (cnt_q == uc.loop_end);
    skip      = (uc.src == SRC_DIGIT) && (digit == '0) && !seen_q && (cnt_q != DigitLastCnt);
    out_free  = !out_valid_q || strobe_o.ready;
    emit      = busy_q && out_free && !skip;
    byte_done = busy_q && (skip || (out_free && (!bus_mode_q || nib_q)));
    run_end   = uc.last && loop_done;
    if (nib_q) begin
      strobe_data = {byte_val[3:0], 4'b0000};
    end else if (bus_mode_q) begin
      strobe_data = {byte_val[7:4], 4'b0000};
    end else begin
      strobe_data = byte_val;
    end
  end

  always_comb begin
    entry_ok = 1'b1;
    unique case (req_cmd_e'(req_i.cmd))
      CMD_INIT:      entry_pc = bus_mode_q ? PcInit4 : PcInit8;
      CMD_CMD_BYTE:  entry_pc = PcCmdByte;
      CMD_DATA_BYTE: entry_pc = PcDataByte;
      CMD_CURSOR:    entry_pc = PcCursor;
      CMD_NUMBER:    entry_pc = PcNumber;
      CMD_GLYPH:     entry_pc = PcGlyph;
      default: begin
        entry_pc = PcInit4;
        entry_ok = 1'b0;
      end
    endcase
  end

  assign req_i.ready = !busy_q;
  assign req_fire    = req_i.valid && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_mode_q   <= 1'b1;
      line1_base_q <= 8'd0;
      line2_base_q <= 8'd64;
      ddram_base_q <= 8'd128;
      cgram_base_q <= 8'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_BUS_MODE:   bus_mode_q   <= cfg_data_i[0];
        REG_LINE1_BASE: line1_base_q <= cfg_data_i;
        REG_LINE2_BASE: line2_base_q <= cfg_data_i;
        REG_DDRAM_BASE: ddram_base_q <= cfg_data_i;
        REG_CGRAM_BASE: cgram_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
      cnt_q  <= '0;
      nib_q  <= 1'b0;
      seen_q <= 1'b0;
    end else if (req_fire) begin
      busy_q <= entry_ok;
      pc_q   <= entry_pc;
      cnt_q  <= '0;
      nib_q  <= 1'b0;
      seen_q <= 1'b0;
    end else begin
      if (emit && bus_mode_q) begin
        nib_q <= !nib_q;
      end
      if (byte_done) begin
        if ((uc.src == SRC_DIGIT) && (digit != '0)) begin
          seen_q <= 1'b1;
        end
        if (!loop_done) begin
          cnt_q <= cnt_q + 3'd1;
        end else begin
          cnt_q <= '0;
          if (run_end) begin
            busy_q <= 1'b0;
          end else begin
            pc_q <= pc_q + 5'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      bv_q  <= req_i.byte_value;
      col_q <= req_i.col;
      row_q <= req_i.row;
      pat_q <= req_i.pattern;
      rem_q <= req_i.number;
    end else if (byte_done && (uc.src == SRC_DIGIT)) begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (strobe_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_rs_q   <= uc.rs;
      out_data_q <= strobe_data;
      out_wait_q <= nib_q ? '0 : uc.wait_ms;
      out_last_q <= run_end && (!bus_mode_q || nib_q);
    end
  end

  assign strobe_o.valid          = out_valid_q;
  assign strobe_o.reg_select     = out_rs_q;
  assign strobe_o.data_lines     = out_data_q;
  assign strobe_o.wait_before_ms = out_wait_q;
  assign strobe_o.last           = out_last_q;

endmodule
